/* hw/rtl/ffc_pkg.sv */
// Shared types, constants and arithmetic helpers for the first-fit free and coalesce unit.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package ffc_pkg;

    localparam int MAX_SEGMENTS = 32;
    localparam int ADDR_WIDTH   = 32;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

    typedef logic [ADDR_WIDTH-1:0] t_addr;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [IDX_W-1:0]      t_idx;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // Update applied by every free-table cell at once.
    typedef enum logic [2:0] {
        K_NONE,
        K_PREV,
        K_NEXT,
        K_BOTH,
        K_INS
    } t_kind;

    typedef struct packed {
        t_kind kind;
        t_cnt  pos;
        t_addr new_addr;
        t_addr new_size;
    } t_free_cmd;

    // Sum that saturates to all ones when it leaves the address width.
    function automatic t_addr f_sat_add(input t_addr a, input t_addr b);
        logic [ADDR_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ADDR_WIDTH] ? '1 : s[ADDR_WIDTH-1:0];
    endfunction

    // A block touches the next one when its end equals that address without carry.
    function automatic logic f_touches(input t_addr a, input t_addr s, input t_addr nxt);
        logic [ADDR_WIDTH:0] e;
        e = {1'b0, a} + {1'b0, s};
        return !e[ADDR_WIDTH] && (e[ADDR_WIDTH-1:0] == nxt);
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/ffc_occ_cell.sv */
// One entry of the occupied-block table: valid flag, address and size.
// Depends on ffc_pkg.
`default_nettype none
module ffc_occ_cell (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  ffc_pkg::t_addr i_key,
    input  wire            i_wr,
    input  wire            i_clr,
    input  ffc_pkg::t_addr i_addr,
    input  ffc_pkg::t_addr i_size,
    output logic           o_valid,
    output logic           o_match,
    output ffc_pkg::t_addr o_size
);
    import ffc_pkg::*;

    logic  r_valid;
    t_addr r_addr;
    t_addr r_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr) begin
            r_valid <= 1'b1;
        end else if (i_clr) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_addr <= i_addr;
            r_size <= i_size;
        end
    end

    assign o_valid = r_valid;
    assign o_match = r_valid && (r_addr == i_key);
    assign o_size  = r_size;

endmodule
`default_nettype wire

/* hw/rtl/ffc_free_cell.sv */
// One entry of the address-sorted free-segment table; shifts to or from its neighbors.
// Depends on ffc_pkg.
`default_nettype none
module ffc_free_cell (
    input  wire               i_clk,
    input  ffc_pkg::t_cnt     i_idx,
    input  ffc_pkg::t_cnt     i_count,
    input  ffc_pkg::t_addr    i_key,
    input  ffc_pkg::t_free_cmd i_cmd,
    input  ffc_pkg::t_addr    i_left_addr,
    input  ffc_pkg::t_addr    i_left_size,
    input  ffc_pkg::t_addr    i_right_addr,
    input  ffc_pkg::t_addr    i_right_size,
    output ffc_pkg::t_addr    o_addr,
    output ffc_pkg::t_addr    o_size,
    output logic              o_lt
);
    import ffc_pkg::*;

    t_addr r_addr, n_addr;
    t_addr r_size, n_size;
    logic  at_prev, at_pos, above_pos;

    assign at_prev   = (CNT_W'(i_idx + 1'b1) == i_cmd.pos);
    assign at_pos    = (i_idx == i_cmd.pos);
    assign above_pos = (i_idx > i_cmd.pos);

    always_comb begin
        n_addr = r_addr;
        n_size = r_size;
        unique case (i_cmd.kind)
            K_PREV: begin
                if (at_prev) n_size = i_cmd.new_size;
            end
            K_NEXT: begin
                if (at_pos) begin
                    n_addr = i_cmd.new_addr;
                    n_size = i_cmd.new_size;
                end
            end
            K_BOTH: begin
                if (at_prev) begin
                    n_size = i_cmd.new_size;
                end else if (at_pos || above_pos) begin
                    n_addr = i_right_addr;
                    n_size = i_right_size;
                end
            end
            K_INS: begin
                if (at_pos) begin
                    n_addr = i_cmd.new_addr;
                    n_size = i_cmd.new_size;
                end else if (above_pos) begin
                    n_addr = i_left_addr;
                    n_size = i_left_size;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_size <= n_size;
    end

    assign o_addr = r_addr;
    assign o_size = r_size;
    assign o_lt   = (i_idx < i_count) && (r_addr < i_key);

endmodule
`default_nettype wire

/* hw/rtl/first_fit_free_coalesce_unit.sv */
// Top level of the first-fit free and coalesce unit: control sequencer and two rows of cells.
// Depends on ffc_pkg, ffc_occ_cell and ffc_free_cell.
//
// Usage. A command is a transfer on start while busy is low: opcode 0 records an
// occupied block (i_block_address, i_block_size), opcode 1 frees the occupied block
// that starts at i_block_address. The freed block is placed in the address-sorted
// free table and merged with the touching segment below and/or above it.
// Every command gives exactly one result, shown for one cycle with o_done high:
// o_status, the resulting free segment on a successful free (zero otherwise), and
// o_free_count, the number of free segments now held.
// Order: a record, and a free whose lookup fails, give their result from the lookup
// step; a free that finds its block goes on through position search, lower merge
// and upper merge, and ends there if it meets a full free table, or else after the
// parallel shift of the free-table cells. busy is high from the transfer until the
// result cycle, so one command is in flight at a time; the next transfer may come
// in the result cycle.
// Reset (synchronous, active low) empties both tables at once through the valid
// flags and the segment count; no clearing pass is needed.
// The receiver cannot stall: each result must be taken in its strobe cycle.
`default_nettype none
module first_fit_free_coalesce_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire         i_opcode,
    input  wire  [31:0] i_block_address,
    input  wire  [31:0] i_block_size,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [31:0] o_segment_address,
    output logic [31:0] o_segment_size,
    output logic [5:0]  o_free_count
);
    import ffc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIND  = 3'd1;
    localparam logic [2:0] S_POS   = 3'd2;
    localparam logic [2:0] S_MERGE = 3'd3;
    localparam logic [2:0] S_NEXT  = 3'd4;
    localparam logic [2:0] S_APPLY = 3'd5;

    logic [2:0] r_state, n_state;

    // Command registers.
    logic  r_op;
    t_addr r_addr, r_size;

    // Working registers of a free.
    t_idx  r_slot;
    t_addr r_bsize;
    t_cnt  r_pos;
    t_addr r_prev_a, r_prev_s, r_next_a, r_next_s;
    logic  r_has_prev, r_has_next;
    logic  r_mp;
    t_addr r_ca, r_cs;
    t_free_cmd r_cmd, n_cmd;
    t_cnt  r_count, n_count;

    // Result registers.
    logic       r_done, n_done;
    logic [1:0] r_status, n_status;
    t_addr      r_seg_a, n_seg_a, r_seg_s, n_seg_s;

    // Occupied row.
    logic [MAX_SEGMENTS-1:0] occ_valid, occ_match, occ_wr, occ_clr;
    t_addr occ_size [MAX_SEGMENTS];

    // Free row.
    t_addr fr_addr [MAX_SEGMENTS];
    t_addr fr_size [MAX_SEGMENTS];
    logic [MAX_SEGMENTS-1:0] fr_lt;
    t_free_cmd cell_cmd;

    assign cell_cmd = (r_state == S_APPLY) ? r_cmd : '{K_NONE, '0, '0, '0};

    genvar g;
    generate
        for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cells
            ffc_occ_cell u_occ (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_key   (r_addr),
                .i_wr    (occ_wr[g]),
                .i_clr   (occ_clr[g]),
                .i_addr  (r_addr),
                .i_size  (r_size),
                .o_valid (occ_valid[g]),
                .o_match (occ_match[g]),
                .o_size  (occ_size[g])
            );
            ffc_free_cell u_free (
                .i_clk        (i_clk),
                .i_idx        (CNT_W'(g)),
                .i_count      (r_count),
                .i_key        (r_addr),
                .i_cmd        (cell_cmd),
                .i_left_addr  ((g == 0) ? '0 : fr_addr[(g == 0) ? 0 : g-1]),
                .i_left_size  ((g == 0) ? '0 : fr_size[(g == 0) ? 0 : g-1]),
                .i_right_addr ((g == MAX_SEGMENTS-1) ? '0
                               : fr_addr[(g == MAX_SEGMENTS-1) ? g : g+1]),
                .i_right_size ((g == MAX_SEGMENTS-1) ? '0
                               : fr_size[(g == MAX_SEGMENTS-1) ? g : g+1]),
                .o_addr       (fr_addr[g]),
                .o_size       (fr_size[g]),
                .o_lt         (fr_lt[g])
            );
        end
    endgenerate

    // Lookup over the occupied row: lowest matching slot and lowest empty slot.
    logic any_valid, found, full;
    t_idx match_idx, empty_idx;
    t_addr match_size;

    always_comb begin
        match_idx = '0;
        empty_idx = '0;
        for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
            if (occ_match[i]) match_idx = IDX_W'(i);
            if (!occ_valid[i]) empty_idx = IDX_W'(i);
        end
        match_size = '0;
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
            if (IDX_W'(i) == match_idx) match_size = occ_size[i];
        end
    end

    assign any_valid = |occ_valid;
    assign found     = |occ_match;
    assign full      = &occ_valid;

    // Position search: the free row is sorted, so the flags form a run from cell 0.
    t_cnt  pos;
    t_addr sel_prev_a, sel_prev_s, sel_next_a, sel_next_s;

    always_comb begin
        pos = r_count;
        for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
            if (!fr_lt[i] && (CNT_W'(i) < r_count)) pos = CNT_W'(i);
        end
        sel_prev_a = '0;
        sel_prev_s = '0;
        sel_next_a = '0;
        sel_next_s = '0;
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
            if (CNT_W'(i + 1) == pos) begin
                sel_prev_a = fr_addr[i];
                sel_prev_s = fr_size[i];
            end
            if (CNT_W'(i) == pos) begin
                sel_next_a = fr_addr[i];
                sel_next_s = fr_size[i];
            end
        end
    end

    logic mn;
    assign mn = r_has_next && f_touches(r_ca, r_cs, r_next_a);

    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        n_status = ST_OK;
        n_seg_a  = '0;
        n_seg_s  = '0;
        n_cmd    = r_cmd;
        n_count  = r_count;
        occ_wr   = '0;
        occ_clr  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_FIND;
            end
            S_FIND: begin
                if (!r_op) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    if (full) n_status = ST_FULL;
                    else occ_wr[empty_idx] = 1'b1;
                end else if (!any_valid) begin
                    n_done   = 1'b1;
                    n_status = ST_EMPTY;
                    n_state  = S_IDLE;
                end else if (!found) begin
                    n_done   = 1'b1;
                    n_status = ST_NOTFOUND;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_POS;
                end
            end
            S_POS:   n_state = S_MERGE;
            S_MERGE: n_state = S_NEXT;
            S_NEXT: begin
                n_cmd.pos = r_pos;
                if (!r_mp && !mn && (r_count >= CNT_W'(MAX_SEGMENTS))) begin
                    n_done   = 1'b1;
                    n_status = ST_FULL;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_APPLY;
                    if (r_mp && mn) begin
                        n_cmd.kind     = K_BOTH;
                        n_cmd.new_addr = r_ca;
                        n_cmd.new_size = f_sat_add(r_cs, r_next_s);
                    end else if (r_mp) begin
                        n_cmd.kind     = K_PREV;
                        n_cmd.new_addr = r_ca;
                        n_cmd.new_size = r_cs;
                    end else if (mn) begin
                        n_cmd.kind     = K_NEXT;
                        n_cmd.new_addr = r_addr;
                        n_cmd.new_size = f_sat_add(r_bsize, r_next_s);
                    end else begin
                        n_cmd.kind     = K_INS;
                        n_cmd.new_addr = r_addr;
                        n_cmd.new_size = r_bsize;
                    end
                end
            end
            S_APPLY: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
                n_seg_a = r_cmd.new_addr;
                n_seg_s = r_cmd.new_size;
                occ_clr[r_slot] = 1'b1;
                if (r_cmd.kind == K_BOTH) n_count = r_count - 1'b1;
                else if (r_cmd.kind == K_INS) n_count = r_count + 1'b1;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_seg_a  <= n_seg_a;
        r_seg_s  <= n_seg_s;
        r_cmd    <= n_cmd;
        if (r_state == S_IDLE && start) begin
            r_op   <= i_opcode;
            r_addr <= ADDR_WIDTH'(i_block_address);
            r_size <= ADDR_WIDTH'(i_block_size);
        end
        if (r_state == S_FIND) begin
            r_slot  <= match_idx;
            r_bsize <= match_size;
        end
        if (r_state == S_POS) begin
            r_pos      <= pos;
            r_has_prev <= (pos != '0);
            r_has_next <= (pos < r_count);
            r_prev_a   <= sel_prev_a;
            r_prev_s   <= sel_prev_s;
            r_next_a   <= sel_next_a;
            r_next_s   <= sel_next_s;
        end
        if (r_state == S_MERGE) begin
            r_mp <= r_has_prev && f_touches(r_prev_a, r_prev_s, r_addr);
            if (r_has_prev && f_touches(r_prev_a, r_prev_s, r_addr)) begin
                r_ca <= r_prev_a;
                r_cs <= f_sat_add(r_prev_s, r_bsize);
            end else begin
                r_ca <= r_addr;
                r_cs <= r_bsize;
            end
        end
    end

    assign busy              = (r_state != S_IDLE);
    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_segment_address = 32'(r_seg_a);
    assign o_segment_size    = 32'(r_seg_s);
    assign o_free_count      = 6'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SEGMENTS))
        else $error("free segment count beyond table size");

    a_count_moves_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> r_done)
        else $error("free segment count changed without a result");

    a_start_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not make the unit busy");

    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("result strobe while a command is still in flight");

endmodule
`default_nettype wire
